// ===== hdl/bsdr_pkg.sv =====
`default_nettype none
package bsdr_pkg;

   localparam int BLOCK_BITS      = 66;
   localparam int WORD_BITS       = 32;
   localparam int HIST_BITS       = 58;
   localparam int HIST_TAP        = 39;
   localparam int PAYLOAD_BITS    = BLOCK_BITS - 2;
   localparam int BUF_BITS        = BLOCK_BITS + WORD_BITS;
   localparam int FILL_BITS       = 7;
   localparam int SLIP_BITS       = 7;
   localparam int COUNT_BITS      = 11;
   localparam int ERR_BITS        = 16;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 11;

   localparam logic [COUNT_BITS-1:0] PRECHECK_BLOCKS = COUNT_BITS'(5);
   localparam logic [SLIP_BITS-1:0]  SLIP_MAX        = SLIP_BITS'(BLOCK_BITS - 1);
   localparam logic [FILL_BITS-1:0]  EXTRACT_FILL    = FILL_BITS'(BLOCK_BITS + 1);

   localparam logic [1:0] HDR_DATA = 2'b01;
   localparam logic [1:0] HDR_CTRL = 2'b10;

   typedef logic [1:0] block_kind_type;
   localparam block_kind_type KIND_DATA  = 2'd0;
   localparam block_kind_type KIND_CTRL  = 2'd1;
   localparam block_kind_type KIND_ERROR = 2'd2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_SAMPLE_SIZE     = 3'd0;
   localparam csr_index_type CSR_THRESHOLD_COUNT = 3'd1;
   localparam csr_index_type CSR_FORCE_MODE      = 3'd2;
   localparam csr_index_type CSR_FORCED_SLIP     = 3'd3;
   localparam csr_index_type CSR_DROP_CONTROL    = 3'd4;

endpackage
`default_nettype wire

// ===== hdl/block_sync_66b_descrambler_rx_unit.sv =====
`default_nettype none
// Receive-side 64b/66b block sync, gearbox and descrambler. One 32-bit line word
// (first bit in the MSB) is taken per clock, with no gaps needed; a 66-bit block
// comes out once enough bits are buffered, so 16 blocks per 33 words (about one
// block every two words). All work for a word is one combinational pass from the
// gearbox register into the result register, so a block shows on the rsp_ port
// in the cycle after the word that completes it. A new word is taken whenever the
// result register is empty or is read in the same cycle, so a block waiting on
// rsp_ready holds the input. While unlocked, the slip
// search drops one bit per failed candidate and walks all 66 slips; search
// blocks are not delivered. Force mode walks the slip one bit per word toward
// forced_slip. Descrambling is x^58+x^39+1 over the raw received payload bits;
// the history clears on every slip change and rsp_history_ok is low for the first
// block after a clear. Configuration writes take effect at once and must be
// made while no word is in flight.
module block_sync_66b_descrambler_rx_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [bsdr_pkg::WORD_BITS-1:0]       req_line_word,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_block_type,
   output logic [bsdr_pkg::PAYLOAD_BITS-1:0]         rsp_payload,
   output logic                                      rsp_history_ok,
   output logic [bsdr_pkg::SLIP_BITS-1:0]            rsp_slip_used,
   output logic [bsdr_pkg::ERR_BITS-1:0]             rsp_error_total,
   input  wire logic                                 csr_write_en,
   input  wire logic [bsdr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [bsdr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import bsdr_pkg::*;

   logic [COUNT_BITS-1:0]   sample_size_ff;
   logic [COUNT_BITS-1:0]   threshold_count_ff;
   logic                    force_mode_ff;
   logic [SLIP_BITS-1:0]    forced_slip_ff;
   logic                    drop_control_ff;

   logic [BUF_BITS-1:0]     gear_bits_ff, gear_bits_in;
   logic [FILL_BITS-1:0]    gear_fill_ff, gear_fill_in;
   logic [SLIP_BITS-1:0]    bit_slip_ff, bit_slip_in;
   logic [HIST_BITS-1:0]    hist_ff, hist_in;
   logic                    hist_loaded_ff, hist_loaded_in;
   logic [COUNT_BITS-1:0]   window_count_ff, window_count_in;
   logic [COUNT_BITS-1:0]   valid_count_ff, valid_count_in;
   logic                    locked_ff, locked_in;
   logic [ERR_BITS-1:0]     error_count_ff, error_count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   block_kind_type          rsp_kind_ff, rsp_kind_in;
   logic [PAYLOAD_BITS-1:0] rsp_payload_ff, rsp_payload_in;
   logic                    rsp_hist_ok_ff, rsp_hist_ok_in;
   logic [SLIP_BITS-1:0]    rsp_slip_ff, rsp_slip_in;
   logic [ERR_BITS-1:0]     rsp_err_ff, rsp_err_in;

   logic                    req_fire;
   logic [SLIP_BITS-1:0]    target_slip;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign target_slip = (forced_slip_ff > SLIP_MAX) ? SLIP_MAX : forced_slip_ff;

   always_comb begin
      logic [1:0]                      hdr;
      logic [PAYLOAD_BITS-1:0]         raw;
      logic [HIST_BITS+PAYLOAD_BITS-1:0] stream;
      logic [PAYLOAD_BITS-1:0]         data;
      logic                            hdr_valid;
      logic                            emit;
      logic                            slip_now;
      block_kind_type                  kind;

      gear_bits_in    = gear_bits_ff;
      gear_fill_in    = gear_fill_ff;
      bit_slip_in     = bit_slip_ff;
      hist_in         = hist_ff;
      hist_loaded_in  = hist_loaded_ff;
      window_count_in = window_count_ff;
      valid_count_in  = valid_count_ff;
      locked_in       = locked_ff;
      error_count_in  = error_count_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_hist_ok_in  = rsp_hist_ok_ff;
      rsp_slip_in     = rsp_slip_ff;
      rsp_err_in      = rsp_err_ff;

      hdr       = 2'b00;
      raw       = '0;
      stream    = '0;
      data      = '0;
      hdr_valid = 1'b0;
      emit      = 1'b0;
      slip_now  = 1'b0;
      kind      = KIND_ERROR;

      if (req_fire) begin
         // append the word right behind the buffered bits
         gear_bits_in = gear_bits_ff
                      | ({req_line_word, {BLOCK_BITS{1'b0}}} >> gear_fill_ff);
         gear_fill_in = gear_fill_ff + FILL_BITS'(WORD_BITS);

         if (force_mode_ff && (bit_slip_ff != target_slip)) begin
            gear_bits_in    = gear_bits_in << 1;
            gear_fill_in    = gear_fill_in - 1'b1;
            bit_slip_in     = (bit_slip_in == SLIP_MAX) ? '0 : bit_slip_in + 1'b1;
            hist_in         = '0;
            hist_loaded_in  = 1'b0;
            window_count_in = '0;
            valid_count_in  = '0;
            locked_in       = 1'b0;
            error_count_in  = '0;
         end

         if (gear_fill_in >= EXTRACT_FILL) begin
            hdr          = gear_bits_in[BUF_BITS-1 -: 2];
            raw          = gear_bits_in[BUF_BITS-3 -: PAYLOAD_BITS];
            gear_bits_in = gear_bits_in << BLOCK_BITS;
            gear_fill_in = gear_fill_in - FILL_BITS'(BLOCK_BITS);

            // out bit = raw bit ^ raw bit 39 earlier ^ raw bit 58 earlier
            stream = {hist_in, raw};
            for (int i = 0; i < PAYLOAD_BITS; i++) begin
               data[i] = stream[i] ^ stream[i+HIST_TAP] ^ stream[i+HIST_BITS];
            end
            rsp_hist_ok_in = hist_loaded_in;
            hist_in        = raw[HIST_BITS-1:0];
            hist_loaded_in = 1'b1;

            hdr_valid = (hdr == HDR_DATA) || (hdr == HDR_CTRL);

            if (force_mode_ff) begin
               emit = (bit_slip_in == target_slip);
            end else if (!locked_in) begin
               if (window_count_in < PRECHECK_BLOCKS) begin
                  if (!hdr_valid) begin
                     slip_now = 1'b1;
                  end else begin
                     window_count_in = window_count_in + 1'b1;
                     valid_count_in  = valid_count_in + 1'b1;
                  end
               end else begin
                  window_count_in = window_count_in + 1'b1;
                  if (hdr_valid) begin
                     valid_count_in = valid_count_in + 1'b1;
                  end
                  if (hdr_valid && (valid_count_in >= threshold_count_ff)) begin
                     locked_in       = 1'b1;
                     window_count_in = '0;
                     valid_count_in  = '0;
                  end else if (window_count_in >= sample_size_ff) begin
                     slip_now = 1'b1;
                  end
               end
            end else begin
               emit = 1'b1;
            end

            if (slip_now) begin
               gear_bits_in    = gear_bits_in << 1;
               gear_fill_in    = gear_fill_in - 1'b1;
               bit_slip_in     = (bit_slip_in == SLIP_MAX) ? '0 : bit_slip_in + 1'b1;
               hist_in         = '0;
               hist_loaded_in  = 1'b0;
               window_count_in = '0;
               valid_count_in  = '0;
               locked_in       = 1'b0;
               error_count_in  = '0;
            end

            if (emit) begin
               case (hdr)
                  HDR_DATA: kind = KIND_DATA;
                  HDR_CTRL: kind = KIND_CTRL;
                  default:  kind = KIND_ERROR;
               endcase
               if ((kind == KIND_ERROR) && (error_count_in != '1)) begin
                  error_count_in = error_count_in + 1'b1;
               end
               // drop control blocks when asked
               if (!((kind == KIND_CTRL) && drop_control_ff)) begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = kind;
                  rsp_payload_in = data;
                  rsp_slip_in    = bit_slip_in;
                  rsp_err_in     = error_count_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_size_ff     <= COUNT_BITS'(64);
         threshold_count_ff <= COUNT_BITS'(60);
         force_mode_ff      <= 1'b0;
         forced_slip_ff     <= '0;
         drop_control_ff    <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SAMPLE_SIZE:     sample_size_ff     <= csr_wdata;
            CSR_THRESHOLD_COUNT: threshold_count_ff <= csr_wdata;
            CSR_FORCE_MODE:      force_mode_ff      <= csr_wdata[0];
            CSR_FORCED_SLIP:     forced_slip_ff     <= csr_wdata[SLIP_BITS-1:0];
            CSR_DROP_CONTROL:    drop_control_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gear_bits_ff    <= '0;
         gear_fill_ff    <= '0;
         bit_slip_ff     <= '0;
         hist_ff         <= '0;
         hist_loaded_ff  <= 1'b0;
         window_count_ff <= '0;
         valid_count_ff  <= '0;
         locked_ff       <= 1'b0;
         error_count_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         gear_bits_ff    <= gear_bits_in;
         gear_fill_ff    <= gear_fill_in;
         bit_slip_ff     <= bit_slip_in;
         hist_ff         <= hist_in;
         hist_loaded_ff  <= hist_loaded_in;
         window_count_ff <= window_count_in;
         valid_count_ff  <= valid_count_in;
         locked_ff       <= locked_in;
         error_count_ff  <= error_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff    <= rsp_kind_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_hist_ok_ff <= rsp_hist_ok_in;
      rsp_slip_ff    <= rsp_slip_in;
      rsp_err_ff     <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_type  = rsp_kind_ff;
   assign rsp_payload     = rsp_payload_ff;
   assign rsp_history_ok  = rsp_hist_ok_ff;
   assign rsp_slip_used   = rsp_slip_ff;
   assign rsp_error_total = rsp_err_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      gear_fill_ff <= FILL_BITS'(BLOCK_BITS))
      else $error("gearbox fill beyond one block");

   a_slip_bound: assert property (@(posedge clock) disable iff (reset)
      bit_slip_ff <= SLIP_MAX)
      else $error("bit slip out of range");

   a_locked_counts: assert property (@(posedge clock) disable iff (reset)
      locked_ff |-> (window_count_ff == '0) && (valid_count_ff == '0))
      else $error("search counters running while locked");

   a_valid_le_window: assert property (@(posedge clock) disable iff (reset)
      valid_count_ff <= window_count_ff)
      else $error("valid header count exceeds window count");

   a_hist_clear: assert property (@(posedge clock) disable iff (reset)
      !hist_loaded_ff |-> (hist_ff == '0))
      else $error("descrambler history not cleared");
`endif

endmodule
`default_nettype wire

// ===== verif/block_sync_66b_descrambler_rx_unit_tb.sv =====
`default_nettype none
module block_sync_66b_descrambler_rx_unit_tb;
   import bsdr_pkg::*;

   localparam int ITEM_TARGET   = 1050;
   localparam int QUIET_WORDS   = 100;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 1000;
   localparam int MAX_REPORTS   = 10;
   localparam csr_index_type CSR_SPARE_INDEX = 3'd5;

   typedef struct packed {
      block_kind_type              kind;
      logic [PAYLOAD_BITS-1:0]     payload;
      logic                        history_ok;
      logic [SLIP_BITS-1:0]        slip;
      logic [ERR_BITS-1:0]         errors;
   } rx_block_type;

   class rx_block_tracker_type;
      logic [COUNT_BITS-1:0] sample_size = 11'd64;
      logic [COUNT_BITS-1:0] threshold_count = 11'd60;
      logic                  force_mode = 1'b0;
      logic [SLIP_BITS-1:0]  forced_slip = '0;
      logic                  drop_control = 1'b0;

      logic [127:0]          gear = '0;
      int                    fill = 0;
      logic [SLIP_BITS-1:0]  slip = '0;
      logic [HIST_BITS-1:0]  history = '0;
      bit                    history_loaded = 0;
      int                    window_count = 0;
      int                    valid_count = 0;
      bit                    locked = 0;
      logic [ERR_BITS-1:0]   error_count = '0;

      rx_block_type          pending_blocks[$];
      int                    faults = 0;

      function void write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_SAMPLE_SIZE:     sample_size = val;
            CSR_THRESHOLD_COUNT: threshold_count = val;
            CSR_FORCE_MODE:      force_mode = val[0];
            CSR_FORCED_SLIP:     forced_slip = val[SLIP_BITS-1:0];
            CSR_DROP_CONTROL:    drop_control = val[0];
            default: ;
         endcase
      endfunction

      function logic [SLIP_BITS-1:0] slip_target();
         return (forced_slip > SLIP_MAX) ? SLIP_MAX : forced_slip;
      endfunction

      // number of slip changes a forced walk to fs needs from here
      function int slips_to(input logic [SLIP_BITS-1:0] fs);
         logic [SLIP_BITS-1:0] target;
         target = (fs > SLIP_MAX) ? SLIP_MAX : fs;
         return (int'(target) - int'(slip) + BLOCK_BITS) % BLOCK_BITS;
      endfunction

      function void slip_change();
         if (fill > 0) begin
            gear = gear << 1;
            fill--;
         end
         slip = (slip == SLIP_MAX) ? '0 : slip + 1'b1;
         history = '0;
         history_loaded = 0;
         window_count = 0;
         valid_count = 0;
         locked = 0;
         error_count = '0;
      endfunction

      function void queue_block(input rx_block_type blk);
         pending_blocks.insert(pending_blocks.size(), blk);
      endfunction

      function logic [PAYLOAD_BITS-1:0] descramble(input logic [PAYLOAD_BITS-1:0] raw);
         logic [PAYLOAD_BITS-1:0] plain;
         logic [HIST_BITS-1:0]    h;
         h = history;
         for (int i = PAYLOAD_BITS - 1; i >= 0; i--) begin
            plain[i] = raw[i] ^ h[HIST_TAP-1] ^ h[HIST_BITS-1];
            h = {h[HIST_BITS-2:0], raw[i]};
         end
         history = h;
         return plain;
      endfunction

      function void take_word(input logic [WORD_BITS-1:0] word);
         logic [1:0]              hdr;
         logic [PAYLOAD_BITS-1:0] raw;
         logic [PAYLOAD_BITS-1:0] plain;
         bit                      hist_ok;
         bit                      good_hdr;
         block_kind_type          kind;
         rx_block_type            blk;
         if (fill + WORD_BITS <= 128) begin
            gear |= {word, 96'd0} >> fill;
            fill += WORD_BITS;
         end
         if (force_mode && slip != slip_target())
            slip_change();
         if (fill < int'(EXTRACT_FILL))
            return;
         hdr = gear[127:126];
         raw = gear[125:62];
         gear = gear << BLOCK_BITS;
         fill -= BLOCK_BITS;
         hist_ok = history_loaded;
         plain = descramble(raw);
         history_loaded = 1;
         good_hdr = (hdr == HDR_DATA) || (hdr == HDR_CTRL);

         if (force_mode) begin
            if (slip != slip_target())
               return;
         end else if (!locked) begin
            if (window_count < PRECHECK_BLOCKS) begin
               if (!good_hdr) begin
                  slip_change();
               end else begin
                  window_count++;
                  valid_count++;
               end
               return;
            end
            window_count++;
            if (good_hdr) begin
               valid_count++;
               if (valid_count >= threshold_count) begin
                  locked = 1;
                  window_count = 0;
                  valid_count = 0;
                  return;
               end
            end
            if (window_count >= sample_size)
               slip_change();
            return;
         end

         if (hdr == HDR_DATA)
            kind = KIND_DATA;
         else if (hdr == HDR_CTRL)
            kind = KIND_CTRL;
         else
            kind = KIND_ERROR;
         if (kind == KIND_ERROR && error_count != '1)
            error_count++;
         if (kind == KIND_CTRL && drop_control)
            return;
         blk.kind = kind;
         blk.payload = plain;
         blk.history_ok = hist_ok;
         blk.slip = slip;
         blk.errors = error_count;
         queue_block(blk);
      endfunction

      function void check_block(input rx_block_type seen);
         rx_block_type want;
         if (pending_blocks.size() == 0) begin
            faults++;
            if (faults <= MAX_REPORTS)
               $display("unexpected block: type %0d payload %h slip %0d",
                        seen.kind, seen.payload, seen.slip);
            return;
         end
         want = pending_blocks.pop_front();
         if (seen.kind !== want.kind || seen.payload !== want.payload ||
             seen.history_ok !== want.history_ok || seen.slip !== want.slip ||
             seen.errors !== want.errors) begin
            faults++;
            if (faults <= MAX_REPORTS)
               $display({"block mismatch (expected/actual): type %0d/%0d payload %h/%h ",
                         "history_ok %b/%b slip %0d/%0d errors %0d/%0d"},
                        want.kind, seen.kind, want.payload, seen.payload,
                        want.history_ok, seen.history_ok, want.slip, seen.slip,
                        want.errors, seen.errors);
         end
      endfunction

      function int pending();
         return pending_blocks.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [WORD_BITS-1:0]       req_line_word = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [1:0]                 rsp_block_type;
   logic [PAYLOAD_BITS-1:0]    rsp_payload;
   logic                       rsp_history_ok;
   logic [SLIP_BITS-1:0]       rsp_slip_used;
   logic [ERR_BITS-1:0]        rsp_error_total;
   logic                       csr_write_en = 1'b0;
   csr_index_type              csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   rx_block_tracker_type tracker = new();
   bit              line_bits[$];
   bit              quiet = 0;
   bit              calm = 0;
   int              words_sent = 0;
   int              stall_left = 0;
   int              stuck_cycles = 0;
   rx_block_type    seen_block;

   block_sync_66b_descrambler_rx_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_line_word   (req_line_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_block_type  (rsp_block_type),
      .rsp_payload     (rsp_payload),
      .rsp_history_ok  (rsp_history_ok),
      .rsp_slip_used   (rsp_slip_used),
      .rsp_error_total (rsp_error_total),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_line_bit(input bit b);
      line_bits.insert(line_bits.size(), b);
   endfunction

   // next word of a framed line stream: headers mostly data, some control, err_pct errors
   function automatic logic [WORD_BITS-1:0] next_line_word(input int err_pct);
      logic [WORD_BITS-1:0] word;
      logic [1:0]           hdr;
      int                   pick;
      while (line_bits.size() < WORD_BITS) begin
         pick = $urandom_range(0, 99);
         if (pick < err_pct)
            hdr = {2{1'($urandom)}};
         else if (pick < err_pct + 20)
            hdr = HDR_CTRL;
         else
            hdr = HDR_DATA;
         add_line_bit(hdr[1]);
         add_line_bit(hdr[0]);
         repeat (PAYLOAD_BITS) add_line_bit(1'($urandom));
      end
      for (int i = WORD_BITS - 1; i >= 0; i--)
         word[i] = line_bits.pop_front();
      return word;
   endfunction

   task automatic send_word(input logic [WORD_BITS-1:0] word);
      if (!(quiet || calm) && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_line_word <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_word(word);
      words_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.write_reg(idx, val);
   endtask

   // hold until every block has been delivered and the pipeline is empty
   task automatic drain();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // offset: bits the block's framing leads the true block boundary once the pad is in
   task automatic run_phase(input logic [COUNT_BITS-1:0] ss, thr, input bit frc,
                            input logic [SLIP_BITS-1:0] fs, input bit drop,
                            input int offset, words, err_pct, input bit noise);
      int pad;
      drain();
      write_reg(CSR_SAMPLE_SIZE, ss);
      write_reg(CSR_THRESHOLD_COUNT, thr);
      write_reg(CSR_FORCE_MODE, {10'($urandom), frc});
      write_reg(CSR_FORCED_SLIP, {4'($urandom), fs});
      write_reg(CSR_DROP_CONTROL, {10'($urandom), drop});
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_SPARE_INDEX + csr_index_type'($urandom_range(0, 2)), 11'($urandom));
      csr_write_en <= 1'b0;
      line_bits.delete();
      pad = ((offset - tracker.fill) % BLOCK_BITS + BLOCK_BITS) % BLOCK_BITS;
      repeat (pad) add_line_bit(1'($urandom));
      repeat (words)
         send_word(noise ? WORD_BITS'($urandom)
                         : next_line_word((tracker.locked || frc) ? err_pct : 2));
      req_valid <= 1'b0;
   endtask

   task automatic force_walk(input logic [COUNT_BITS-1:0] ss, thr,
                             input logic [SLIP_BITS-1:0] fs, input bit drop, input int err_pct);
      int walk;
      walk = tracker.slips_to(fs);
      run_phase(ss, thr, 1'b1, fs, drop, walk, walk + $urandom_range(10, 40), err_pct, 1'b0);
   endtask

   task automatic search(input logic [COUNT_BITS-1:0] ss, thr, input logic [SLIP_BITS-1:0] fs,
                         input bit drop, input int err_pct, input int extra);
      int offset;
      if (tracker.locked)
         offset = 0;
      else if ($urandom_range(0, 4) == 0)
         offset = $urandom_range(0, BLOCK_BITS - 1);
      else
         offset = $urandom_range(0, 6);
      run_phase(ss, thr, 1'b0, fs, drop, offset, extra + 4 * offset, err_pct, 1'b0);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_block.kind = rsp_block_type;
            seen_block.payload = rsp_payload;
            seen_block.history_ok = rsp_history_ok;
            seen_block.slip = rsp_slip_used;
            seen_block.errors = rsp_error_total;
            tracker.check_block(seen_block);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= (stall_left == 0);
         end else if (!(quiet || calm) && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("block_sync_66b_descrambler_rx_unit test failed");
         $finish;
      end
   end

   initial begin
      logic [WORD_BITS-1:0]  edge_words[$];
      logic [COUNT_BITS-1:0] ss;
      logic [COUNT_BITS-1:0] thr;
      logic [SLIP_BITS-1:0]  fs;
      bit                    drop;
      edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'h8000_0000, 32'h0000_0001, 32'hC000_0000, 32'h3FFF_FFFF};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // extreme words while searching with reset settings
      foreach (edge_words[i]) send_word(edge_words[i]);
      req_valid <= 1'b0;

      // out-of-range forced slip clamps to the top slip
      force_walk(11'd5, 11'd1024, 7'd127, 1'b0, 15);
      // leave force mode after a walk: search restarts, control blocks dropped
      search(11'd5, 11'd5, 7'd127, 1'b1, 10, 60);
      // force at the current slip: no slip change, lock and history survive
      run_phase(11'd1024, 11'd1024, 1'b1, tracker.slip, 1'b0, 0, 40, 25, 1'b0);
      search(11'd1024, 11'd1024, 7'd0, 1'b1, 5, 40);
      force_walk(11'd0, 11'd0, 7'd0, 1'b0, 10);
      search(11'd0, 11'd0, 7'd0, 1'b0, 10, 60);
      force_walk(11'd2047, 11'd2047, 7'((tracker.slip + 33) % BLOCK_BITS), 1'b1, 5);
      run_phase(11'd2047, 11'd2047, 1'b0, 7'd65, 1'b1, 0, 40, 0, 1'b1);
      search(11'd1024, 11'd5, 7'd65, 1'b0, 10, 60);

      while (words_sent < ITEM_TARGET - QUIET_WORDS) begin
         calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0:       ss = 11'd5;
            1:       ss = 11'd1024;
            default: ss = 11'($urandom_range(5, 120));
         endcase
         thr = 11'($urandom_range(5, (ss > 60) ? 54 : ss - ss / 8));
         if ($urandom_range(0, 7) == 0)
            fs = 7'($urandom_range(BLOCK_BITS, 127));
         else
            fs = 7'($urandom_range(0, BLOCK_BITS - 1));
         drop = 1'($urandom);
         if ($urandom_range(0, 7) == 0) begin
            run_phase(ss, thr, 1'b0, fs, drop, 0, $urandom_range(20, 40), 0, 1'b1);
         end else begin
            if (!tracker.locked || $urandom_range(0, 2) == 0)
               force_walk(ss, thr, fs, drop, $urandom_range(0, 20));
            search(ss, thr, fs, drop, $urandom_range(0, 25), $urandom_range(40, 120));
         end
      end

      calm = 0;
      quiet = 1;
      search(11'd64, 11'd8, 7'd0, 1'b0, 10, QUIET_WORDS);
      drain();
      repeat (20) @(posedge clock);

      if (tracker.faults == 0 && tracker.pending() == 0)
         $display("block_sync_66b_descrambler_rx_unit test passed");
      else
         $display("block_sync_66b_descrambler_rx_unit test failed");
      $finish;
   end

endmodule
`default_nettype wire
